[design/float48_multiplier_core_assert.svh]
// Assertion macros for the float48 multiplier RTL.
`ifndef FLOAT48_MULTIPLIER_CORE_ASSERT_SVH
`define FLOAT48_MULTIPLIER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FM48_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fm48 assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FM48_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fm48 assertion failed");

`endif

[design/fm48_pkg.sv]
// Package with constants and types for the float48 multiplier.
package fm48_pkg;

   localparam int MANT_BITS          = 40;
   localparam int EXP_BITS           = 8;
   localparam int WORD_BITS          = MANT_BITS + EXP_BITS;
   localparam int EXP_BIAS           = 128;
   localparam int EXP_CALC_BITS      = EXP_BITS + 2;
   localparam int Z88_CLEAR_BITS     = 8;
   localparam int DIGIT_BITS_DEFAULT = 8;

   typedef struct packed {
      logic [WORD_BITS-1:0] operand_a;
      logic [WORD_BITS-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] product;
      logic                 exponent_wrapped;
   } rsp_type;

   typedef struct packed {
      logic                 bypass;
      logic [WORD_BITS-1:0] bypass_word;
      logic                 neg;
      logic [EXP_BITS:0]    exp_sum;
   } side_type;

endpackage

[design/float48_multiplier_core.sv]
// Top level of the pipelined 48-bit float multiplier.
//
// Multiplies two 6-byte floats: a 40-bit mantissa whose top bit is the sign
// and an 8-bit exponent biased by 128, where exponent zero means zero.
// Operand pairs arrive on the req_ channel and results leave on the rsp_
// channel; both use valid and stall, and a transfer happens on a clock edge
// with valid high and stall low. The csr_ port writes the z88_mode bit, which
// clears the lowest mantissa byte of every computed result.
// The mantissa product is formed by a row of CELL_COUNT cells, each adding
// the first operand times one DIGIT_BITS-wide digit of the second, followed
// by a normalize stage that drives the result register. One transfer is
// accepted every cycle while req_stall is low. When the receiver stalls,
// results keep entering the empty stages behind the result register, and
// req_stall rises only when every stage holds an item. Synchronous reset
// empties all stages and clears z88_mode.
module float48_multiplier_core #(
   parameter int DIGIT_BITS = fm48_pkg::DIGIT_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fm48_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fm48_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);
   import fm48_pkg::*;

   `include "float48_multiplier_core_assert.svh"

   localparam int CELL_COUNT = (MANT_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int MB_BITS    = CELL_COUNT * DIGIT_BITS;

   logic                 z88_mode_ff;
   logic [EXP_BITS-1:0]  exp_a, exp_b;
   side_type             side_req;
   logic [MANT_BITS-1:0] ma_req;
   logic [MB_BITS-1:0]   mb_req;

   logic                 valid_chain [0:CELL_COUNT];
   logic                 ready_chain [0:CELL_COUNT];
   side_type             side_chain  [0:CELL_COUNT];
   logic [MANT_BITS-1:0] ma_chain    [0:CELL_COUNT];
   logic [MB_BITS-1:0]   mb_chain    [0:CELL_COUNT];
   logic [MANT_BITS-1:0] acc_chain   [0:CELL_COUNT];
   logic [MB_BITS-1:0]   low_chain   [0:CELL_COUNT];
   logic [CELL_COUNT-1:0] cell_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         z88_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         z88_mode_ff <= csr_write_data;
      end
   end

   assign exp_a = req_data.operand_a[WORD_BITS-1:MANT_BITS];
   assign exp_b = req_data.operand_b[WORD_BITS-1:MANT_BITS];

   always_comb begin
      side_req.bypass      = (exp_a == '0) || (exp_b == '0);
      side_req.bypass_word = (exp_a == '0) ? req_data.operand_a : req_data.operand_b;
      side_req.neg         = req_data.operand_a[MANT_BITS-1] ^ req_data.operand_b[MANT_BITS-1];
      side_req.exp_sum     = {1'b0, exp_a} + {1'b0, exp_b};
      ma_req               = {1'b1, req_data.operand_a[MANT_BITS-2:0]};
      mb_req               = MB_BITS'({1'b1, req_data.operand_b[MANT_BITS-2:0]});
   end

   assign valid_chain[0] = req_valid;
   assign side_chain[0]  = side_req;
   assign ma_chain[0]    = ma_req;
   assign mb_chain[0]    = mb_req;
   assign acc_chain[0]   = '0;
   assign low_chain[0]   = '0;
   assign req_stall      = !ready_chain[0];

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      fm48_cell #(
         .DIGIT_BITS(DIGIT_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (valid_chain[i]),
         .in_ready (ready_chain[i]),
         .in_side  (side_chain[i]),
         .in_ma    (ma_chain[i]),
         .in_mb    (mb_chain[i]),
         .in_acc   (acc_chain[i]),
         .in_low   (low_chain[i]),
         .out_valid(valid_chain[i+1]),
         .out_ready(ready_chain[i+1]),
         .out_side (side_chain[i+1]),
         .out_ma   (ma_chain[i+1]),
         .out_mb   (mb_chain[i+1]),
         .out_acc  (acc_chain[i+1]),
         .out_low  (low_chain[i+1])
      );
      assign cell_valid[i] = valid_chain[i+1];
   end

   fm48_norm #(
      .DIGIT_BITS(DIGIT_BITS)
   ) u_norm (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_chain[CELL_COUNT]),
      .in_ready (ready_chain[CELL_COUNT]),
      .in_side  (side_chain[CELL_COUNT]),
      .in_acc   (acc_chain[CELL_COUNT]),
      .in_low   (low_chain[CELL_COUNT]),
      .z88_mode (z88_mode_ff),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   `FM48_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall, cell_valid[0])
   `FM48_ASSERT_SAME(a_full_and_stalled, clock, reset,
      rsp_valid && rsp_stall && (&cell_valid), req_stall)
   `FM48_ASSERT_NEXT(a_output_drains, clock, reset,
      rsp_valid && !rsp_stall && !cell_valid[CELL_COUNT-1], !rsp_valid)

endmodule

[design/fm48_cell.sv]
// One multiply cell: adds the operand times one multiplier digit and retires a digit.
module fm48_cell #(
   parameter int DIGIT_BITS = fm48_pkg::DIGIT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  fm48_pkg::side_type            in_side,
   input  logic [fm48_pkg::MANT_BITS-1:0] in_ma,
   input  logic [((fm48_pkg::MANT_BITS + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS - 1:0] in_mb,
   input  logic [fm48_pkg::MANT_BITS-1:0] in_acc,
   input  logic [((fm48_pkg::MANT_BITS + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS - 1:0] in_low,
   output logic                          out_valid,
   input  logic                          out_ready,
   output fm48_pkg::side_type            out_side,
   output logic [fm48_pkg::MANT_BITS-1:0] out_ma,
   output logic [((fm48_pkg::MANT_BITS + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS - 1:0] out_mb,
   output logic [fm48_pkg::MANT_BITS-1:0] out_acc,
   output logic [((fm48_pkg::MANT_BITS + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS - 1:0] out_low
);
   import fm48_pkg::*;

   localparam int CELL_COUNT = (MANT_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int MB_BITS    = CELL_COUNT * DIGIT_BITS;
   localparam int SUM_BITS   = MANT_BITS + DIGIT_BITS;

   logic                  valid_ff;
   side_type              side_ff;
   logic [MANT_BITS-1:0]  ma_ff;
   logic [MB_BITS-1:0]    mb_ff, mb_in;
   logic [MANT_BITS-1:0]  acc_ff, acc_in;
   logic [MB_BITS-1:0]    low_ff, low_in;
   logic [SUM_BITS-1:0]   partial;
   logic [SUM_BITS-1:0]   sum;

   assign partial = {{DIGIT_BITS{1'b0}}, in_ma} * {{MANT_BITS{1'b0}}, in_mb[DIGIT_BITS-1:0]};
   assign sum     = {{DIGIT_BITS{1'b0}}, in_acc} + partial;
   assign acc_in  = sum[SUM_BITS-1:DIGIT_BITS];
   assign low_in  = {sum[DIGIT_BITS-1:0], in_low[MB_BITS-1:DIGIT_BITS]};
   assign mb_in   = {{DIGIT_BITS{1'b0}}, in_mb[MB_BITS-1:DIGIT_BITS]};

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         side_ff <= in_side;
         ma_ff   <= in_ma;
         mb_ff   <= mb_in;
         acc_ff  <= acc_in;
         low_ff  <= low_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_ma    = ma_ff;
   assign out_mb    = mb_ff;
   assign out_acc   = acc_ff;
   assign out_low   = low_ff;

endmodule

[design/fm48_norm.sv]
// Normalize, exponent and packing stage with the result register.
module fm48_norm #(
   parameter int DIGIT_BITS = fm48_pkg::DIGIT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  fm48_pkg::side_type            in_side,
   input  logic [fm48_pkg::MANT_BITS-1:0] in_acc,
   input  logic [((fm48_pkg::MANT_BITS + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS - 1:0] in_low,
   input  logic                          z88_mode,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fm48_pkg::rsp_type             rsp_data
);
   import fm48_pkg::*;

   localparam int CELL_COUNT = (MANT_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int MB_BITS    = CELL_COUNT * DIGIT_BITS;
   localparam int PROD_BITS  = MANT_BITS + MB_BITS;
   localparam int TOP_BIT    = 2 * MANT_BITS - 1;

   logic [PROD_BITS-1:0]     prod;
   logic                     shift;
   logic [MANT_BITS-1:0]     mant;
   logic [EXP_CALC_BITS-1:0] exp_full;
   logic                     valid_ff;
   rsp_type                  data_ff, data_in;

   assign prod  = {in_acc, in_low};
   assign shift = !prod[TOP_BIT];

   always_comb begin
      mant = shift ? prod[TOP_BIT-1 -: MANT_BITS] : prod[TOP_BIT -: MANT_BITS];
      mant[MANT_BITS-1] = in_side.neg;
      if (z88_mode) begin
         mant[Z88_CLEAR_BITS-1:0] = '0;
      end
   end

   assign exp_full = {1'b0, in_side.exp_sum} - EXP_CALC_BITS'(EXP_BIAS)
                     - {{(EXP_CALC_BITS-1){1'b0}}, shift};

   always_comb begin
      if (in_side.bypass) begin
         data_in.product          = in_side.bypass_word;
         data_in.exponent_wrapped = 1'b0;
      end else begin
         data_in.product          = {exp_full[EXP_BITS-1:0], mant};
         data_in.exponent_wrapped = exp_full[EXP_CALC_BITS-1] | exp_full[EXP_BITS];
      end
   end

   assign in_ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
